[hw/rtl/sm4_block_encrypt_defines.svh]
// Assertion macros of the SM4 encryption RTL, used by the round cell.
`ifndef SM4_BLOCK_ENCRYPT_DEFINES_SVH
`define SM4_BLOCK_ENCRYPT_DEFINES_SVH

`ifndef SYNTHESIS
// Whole property, clocked on clk_i, held off during reset
`define SM4_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next
`define SM4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define SM4_ASSERT(lbl, prop, msg)
`define SM4_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/sm4_pkg.sv]
// Types, constants and round functions of the SM4 encryption pipeline.
`timescale 1ns / 1ps

package sm4_pkg;

  typedef logic [31:0] word_t;
  // Four-word window, element 0 is the oldest word
  typedef word_t [3:0] quad_t;
  typedef logic [255:0][7:0] sbox_tab_t;

  // Data and key window carried from cell to cell
  typedef struct packed {
    quad_t x;
    quad_t k;
  } stage_t;

  localparam int NumRounds = 32;

  // Configuration register indexes
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD0 = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD1 = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD2 = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_WORD3 = 8'd3;

  // System parameter FK, element 0 pairs with key word 0
  localparam quad_t FK = {32'hb27022dc, 32'h677d9197, 32'h56aa3350, 32'ha3b1bac6};

  localparam logic [7:0] AffineMask  = 8'hA7;
  localparam logic [7:0] AffineConst = 8'hD3;
  localparam logic [7:0] GfReduce    = 8'hF5;

  function automatic logic [7:0] rotl8(logic [7:0] v, int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic word_t rotl32(word_t w, int n);
    return (w << n) | (w >> (32 - n));
  endfunction

  function automatic logic [7:0] affine_map(logic [7:0] v);
    logic [7:0] r;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      r[b] = ^(v & rotl8(AffineMask, b));
    end
    return r ^ AffineConst;
  endfunction

  // Multiply in GF(2^8) modulo x^8 + 0xF5
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    logic [7:0] aa;
    p  = '0;
    aa = a;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) p = p ^ aa;
      aa = aa[7] ? ((aa << 1) ^ GfReduce) : (aa << 1);
    end
    return p;
  endfunction

  // Table built at elaboration: affine, field inverse (zero to zero), affine
  function automatic sbox_tab_t build_sbox();
    sbox_tab_t  tab;
    logic [7:0] a;
    logic [7:0] inv;
    for (int v = 0; v < 256; v++) begin
      a   = affine_map(v[7:0]);
      inv = '0;
      if (a != 8'd0) begin
        for (int y = 1; y < 256; y++) begin
          if (gf_mul(a, y[7:0]) == 8'd1) inv = y[7:0];
        end
      end
      tab[v[7:0]] = affine_map(inv);
    end
    return tab;
  endfunction

  localparam sbox_tab_t SBOX = build_sbox();

  function automatic word_t tau(word_t w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Linear map of the data rounds
  function automatic word_t lin_data(word_t t);
    return t ^ rotl32(t, 2) ^ rotl32(t, 10) ^ rotl32(t, 18) ^ rotl32(t, 24);
  endfunction

  // Linear map of the key schedule
  function automatic word_t lin_key(word_t t);
    return t ^ rotl32(t, 13) ^ rotl32(t, 23);
  endfunction

  // Round constant CK: byte j of round r is (4r+j)*7 mod 256
  function automatic word_t ck_word(int r);
    word_t c;
    int    b;
    c = '0;
    for (int j = 0; j < 4; j++) begin
      b = (4 * r + j) * 7;
      c = {c[23:0], b[7:0]};
    end
    return c;
  endfunction

endpackage

[hw/rtl/sm4_if.sv]
// Stream interfaces of the SM4 encryption block: plaintext, ciphertext, config.
`timescale 1ns / 1ps

interface sm4_plain_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_high;
  logic [63:0] plain_low;

  modport source (output valid, output plain_high, output plain_low, input ready);
  modport sink (input valid, input plain_high, input plain_low, output ready);
endinterface

interface sm4_cipher_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;

  modport source (output valid, output cipher_high, output cipher_low, input ready);
  modport sink (input valid, input cipher_high, input cipher_low, output ready);
endinterface

interface sm4_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[hw/rtl/sm4_round_cell.sv]
// One SM4 round cell: one key schedule step and one data round, registered.
`timescale 1ns / 1ps
`include "sm4_block_encrypt_defines.svh"

module sm4_round_cell import sm4_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  word_t  ck_i,
  input  logic   valid_i,
  output logic   ready_o,
  input  stage_t data_i,
  output logic   valid_o,
  input  logic   ready_i,
  output stage_t data_o
);

  logic   valid_q, valid_d;
  stage_t data_q, data_d;
  word_t  key_tau, rkey, data_tau, new_x;

  // Round key from the key window, then one data round with it
  always_comb begin
    key_tau  = tau(data_i.k[1] ^ data_i.k[2] ^ data_i.k[3] ^ ck_i);
    rkey     = data_i.k[0] ^ lin_key(key_tau);
    data_tau = tau(data_i.x[1] ^ data_i.x[2] ^ data_i.x[3] ^ rkey);
    new_x    = data_i.x[0] ^ lin_data(data_tau);
    data_d.k = {rkey, data_i.k[3], data_i.k[2], data_i.k[1]};
    data_d.x = {new_x, data_i.x[3], data_i.x[2], data_i.x[1]};
  end

  // Slot is free when empty or when its beat moves on this cycle
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  `SM4_ASSERT_NEXT(a_hold_valid, valid_q && !ready_i, valid_q, "stalled beat dropped")
  `SM4_ASSERT_NEXT(a_hold_data, valid_q && !ready_i, $stable(data_q), "stalled beat changed")
  `SM4_ASSERT(a_fill, (valid_i && ready_o) |=> valid_q, "accepted beat not held")
  `SM4_ASSERT_NEXT(a_drain, valid_q && ready_i && !valid_i, !valid_q, "beat repeated")

endmodule

[hw/rtl/sm4_block_encrypt.sv]
// SM4 encryption top level: key registers and a chain of 32 round cells.
// A plaintext block accepted at the input is registered in each of the 32
// round cells in turn before its ciphertext is valid at the output, and the
// block takes a new block every cycle while the output is not stalled. Each
// cell does one key schedule step and one data round and hands its window
// to the next cell; the last cell's register is the output register. Ready
// runs back through the chain, so a stall at the output only holds cells
// that are full, and empty slots ahead of it keep filling. The key sits in
// four 32-bit registers (index 0 is the most significant word, reset zero,
// writes to other indexes are ignored); round keys are derived anew for each
// block, so write the key only while no block is in flight.
`timescale 1ns / 1ps

module sm4_block_encrypt import sm4_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sm4_cfg_if.sink      cfg_i,
  sm4_plain_if.sink    plain_i,
  sm4_cipher_if.source cipher_o
);

  quad_t  key_q;
  logic   stage_valid [NumRounds+1];
  logic   stage_ready [NumRounds+1];
  stage_t stage_data  [NumRounds+1];

  // Key register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_KEY_WORD0: key_q[0] <= cfg_i.wdata;
        REG_KEY_WORD1: key_q[1] <= cfg_i.wdata;
        REG_KEY_WORD2: key_q[2] <= cfg_i.wdata;
        REG_KEY_WORD3: key_q[3] <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // Head of the chain: plaintext window and key whitened with FK
  assign stage_valid[0]     = plain_i.valid;
  assign plain_i.ready      = stage_ready[0];
  assign stage_data[0].x[0] = plain_i.plain_high[63:32];
  assign stage_data[0].x[1] = plain_i.plain_high[31:0];
  assign stage_data[0].x[2] = plain_i.plain_low[63:32];
  assign stage_data[0].x[3] = plain_i.plain_low[31:0];
  assign stage_data[0].k    = key_q ^ FK;

  // Round cells
  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    sm4_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ck_i    (ck_word(r)),
      .valid_i (stage_valid[r]),
      .ready_o (stage_ready[r]),
      .data_i  (stage_data[r]),
      .valid_o (stage_valid[r+1]),
      .ready_i (stage_ready[r+1]),
      .data_o  (stage_data[r+1])
    );
  end

  // Tail: final word reversal
  assign stage_ready[NumRounds] = cipher_o.ready;
  assign cipher_o.valid         = stage_valid[NumRounds];
  assign cipher_o.cipher_high   = {stage_data[NumRounds].x[3], stage_data[NumRounds].x[2]};
  assign cipher_o.cipher_low    = {stage_data[NumRounds].x[1], stage_data[NumRounds].x[0]};

endmodule

[sim/sm4_block_encrypt_tb.sv]
// Self-checking testbench for the SM4 block encryption pipeline.
`timescale 1ns / 1ps

module sm4_block_encrypt_tb import sm4_pkg::*; ();

  // Cipher constants: system parameter words (index 0 pairs with key word 0)
  localparam logic [3:0][31:0] FkWords = {32'hb27022dc, 32'h677d9197,
                                          32'h56aa3350, 32'ha3b1bac6};
  localparam logic [7:0]  AffMask  = 8'hA7;
  localparam logic [7:0]  AffXor   = 8'hD3;
  localparam logic [14:0] FieldPoly = 15'h1F5;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_blk_t;

  logic clk_i;
  logic rst_ni;

  sm4_cfg_if    cfg_bus ();
  sm4_plain_if  plain_bus ();
  sm4_cipher_if cipher_bus ();

  sm4_block_encrypt dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .plain_i  (plain_bus),
    .cipher_o (cipher_bus)
  );

  // Key as the block holds it, S-box table, expected ciphertext in order
  logic [3:0][31:0] key_regs;
  logic [7:0]       sbox_lut [256];
  cipher_blk_t      pending_cipher_q [$];
  cipher_blk_t      want_blk;
  int               err_cnt;
  int               src_idle_pct;
  int               snk_stall_pct;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Cipher predictor

  function automatic logic [7:0] rol8(logic [7:0] v, int n);
    logic [15:0] d;
    d = {v, v} << n;
    return d[15:8];
  endfunction

  function automatic word_t rol32(word_t w, int n);
    return (w << n) | (w >> (32 - n));
  endfunction

  // Carry-less product reduced by the field polynomial, top bit first
  function automatic logic [7:0] gf_prod(logic [7:0] a, logic [7:0] b);
    logic [14:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) if (b[i]) p ^= 15'(a) << i;
    for (int i = 14; i >= 8; i--) if (p[i]) p ^= FieldPoly << (i - 8);
    return p[7:0];
  endfunction

  // a^254 is the field inverse, and zero stays zero
  function automatic logic [7:0] gf_recip(logic [7:0] a);
    logic [7:0] acc;
    logic [7:0] pw;
    logic [7:0] e;
    acc = 8'd1;
    pw  = a;
    e   = 8'd254;
    for (int i = 0; i < 8; i++) begin
      if (e[i]) acc = gf_prod(acc, pw);
      pw = gf_prod(pw, pw);
    end
    return acc;
  endfunction

  function automatic logic [7:0] aff_xform(logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[k] = ^(v & rol8(AffMask, k));
    return r ^ AffXor;
  endfunction

  function automatic word_t sub_word(word_t w);
    return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
  endfunction

  function automatic word_t round_ck(int r);
    word_t c;
    int    b;
    c = '0;
    for (int j = 0; j < 4; j++) begin
      b = ((4 * r + j) * 7) & 255;
      c = (c << 8) | word_t'(b);
    end
    return c;
  endfunction

  // Key schedule interleaved with the 32 data rounds, then word reversal
  function automatic cipher_blk_t sm4_encrypt(logic [3:0][31:0] mk, logic [63:0] hi,
                                              logic [63:0] lo);
    word_t       k [4];
    word_t       x [4];
    word_t       t;
    word_t       rk;
    cipher_blk_t res;
    for (int i = 0; i < 4; i++) k[i] = mk[i] ^ FkWords[i];
    x[0] = hi[63:32];
    x[1] = hi[31:0];
    x[2] = lo[63:32];
    x[3] = lo[31:0];
    for (int r = 0; r < 32; r++) begin
      t  = sub_word(k[(r + 1) % 4] ^ k[(r + 2) % 4] ^ k[(r + 3) % 4] ^ round_ck(r));
      rk = k[r % 4] ^ t ^ rol32(t, 13) ^ rol32(t, 23);
      k[r % 4] = rk;
      t  = sub_word(x[(r + 1) % 4] ^ x[(r + 2) % 4] ^ x[(r + 3) % 4] ^ rk);
      x[r % 4] ^= t ^ rol32(t, 2) ^ rol32(t, 10) ^ rol32(t, 18) ^ rol32(t, 24);
    end
    res.cipher_high = {x[3], x[2]};
    res.cipher_low  = {x[1], x[0]};
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Ciphertext sink: random stall and in-order compare

  always @(posedge clk_i) begin
    if (cipher_bus.valid && cipher_bus.ready) begin
      if (pending_cipher_q.size() == 0) begin
        $error("cipher beat with no block pending: %h %h",
               cipher_bus.cipher_high, cipher_bus.cipher_low);
        err_cnt++;
      end else begin
        want_blk = pending_cipher_q.pop_front();
        if (cipher_bus.cipher_high !== want_blk.cipher_high) begin
          $error("cipher_high: expected %h, actual %h",
                 want_blk.cipher_high, cipher_bus.cipher_high);
          err_cnt++;
        end
        if (cipher_bus.cipher_low !== want_blk.cipher_low) begin
          $error("cipher_low: expected %h, actual %h",
                 want_blk.cipher_low, cipher_bus.cipher_low);
          err_cnt++;
        end
      end
    end
    cipher_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Drivers

  // One plaintext beat; valid stays up afterwards so back-to-back beats stream
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    while ($urandom_range(99) < src_idle_pct) begin
      plain_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    plain_bus.valid      <= 1'b1;
    plain_bus.plain_high <= hi;
    plain_bus.plain_low  <= lo;
    do @(posedge clk_i); while (!plain_bus.ready);
    pending_cipher_q.push_back(sm4_encrypt(key_regs, hi, lo));
  endtask

  // Stop sending and wait until every pending ciphertext is back
  task automatic wait_drained();
    plain_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cipher_q.size() != 0);
  endtask

  // Register write; only issued with the pipeline empty
  task automatic write_key_reg(input logic [7:0] idx, input word_t val);
    cfg_bus.index <= idx;
    cfg_bus.wdata <= val;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      REG_KEY_WORD0: key_regs[0] = val;
      REG_KEY_WORD1: key_regs[1] = val;
      REG_KEY_WORD2: key_regs[2] = val;
      REG_KEY_WORD3: key_regs[3] = val;
      default: ;  // unmapped index, no effect
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_key(input word_t w0, input word_t w1, input word_t w2, input word_t w3);
    wait_drained();
    write_key_reg(REG_KEY_WORD0, w0);
    write_key_reg(REG_KEY_WORD1, w1);
    write_key_reg(REG_KEY_WORD2, w2);
    write_key_reg(REG_KEY_WORD3, w3);
  endtask

  // Mostly random words, with all-zero and all-one words mixed in
  function automatic word_t pick_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests

  // Key registers still at their reset value of zero
  task automatic test_reset_key();
    send_block(64'h0, 64'h0);
    send_block('1, '1);
    send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    wait_drained();
  endtask

  // Published test vector, plus the predictor checked against it
  task automatic test_known_answer();
    cipher_blk_t kat;
    load_key(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
    kat = sm4_encrypt(key_regs, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    if (kat !== {64'h681e_df34_d206_965e, 64'h86b3_e94f_536e_4246}) begin
      $error("predictor: expected %h, actual %h",
             {64'h681e_df34_d206_965e, 64'h86b3_e94f_536e_4246}, kat);
      err_cnt++;
    end
    send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    send_block(64'hfedc_ba98_7654_3210, 64'h0123_4567_89ab_cdef);
    wait_drained();
  endtask

  // All-ones key with extreme and single-bit plaintexts
  task automatic test_key_extremes();
    load_key('1, '1, '1, '1);
    send_block(64'h0, 64'h0);
    send_block('1, '1);
    send_block(64'h8000_0000_0000_0000, 64'h0);
    send_block(64'h0, 64'h0000_0000_0000_0001);
    send_block(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
    wait_drained();
  endtask

  // Writes to indexes past the key words leave the key untouched
  task automatic test_ignored_index();
    load_key(32'h0f1e_2d3c, 32'h4b5a_6978, 32'h8796_a5b4, 32'hc3d2_e1f0);
    write_key_reg(8'd4, 32'hdead_beef);
    write_key_reg(8'h80, 32'hffff_ffff);
    write_key_reg(8'hff, 32'h0000_0000);
    send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    send_block(64'h0, '1);
    wait_drained();
  endtask

  // Random blocks under four flow-control settings, a new key each time
  task automatic test_random_traffic();
    int idle_set  [4];
    int stall_set [4];
    idle_set  = '{0, 47, 0, 31};
    stall_set = '{0, 0, 47, 31};
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      src_idle_pct  = idle_set[ph];
      snk_stall_pct = stall_set[ph];
      case (ph)
        0:       load_key($urandom, $urandom, $urandom, $urandom);
        1:       load_key(32'h0, 32'hffff_ffff, $urandom, $urandom);
        2:       load_key(pick_word(), pick_word(), pick_word(), pick_word());
        default: load_key(32'h0, 32'h0, 32'h0, 32'h0);
      endcase
      // Stray write to an unmapped index
      write_key_reg(8'($urandom_range(255, 4)), $urandom);
      for (int n = 0; n < 100; n++) begin
        // Runs without gaps now and then, even in the idling phases
        if (n % 25 == 12) begin
          src_idle_pct = 0;
        end else if (n % 25 == 20) begin
          src_idle_pct = idle_set[ph];
        end
        send_block({pick_word(), pick_word()}, {pick_word(), pick_word()});
      end
    end
    wait_drained();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence

  initial begin
    err_cnt       = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    key_regs      = '0;
    for (int v = 0; v < 256; v++) sbox_lut[v] = aff_xform(gf_recip(aff_xform(v[7:0])));

    rst_ni               <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= '0;
    cfg_bus.wdata        <= '0;
    plain_bus.valid      <= 1'b0;
    plain_bus.plain_high <= '0;
    plain_bus.plain_low  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_key();
    test_known_answer();
    test_key_extremes();
    test_ignored_index();
    test_random_traffic();

    // Let the pipeline empty out; any late beat is caught by the sink
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && pending_cipher_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
